@@ rtl/sbpe_pkg.sv @@
package sbpe_pkg;

   localparam int KEY_MAX = 256;
   localparam int MAX_RESTARTS = 32;
   localparam int KEY_AW = $clog2(KEY_MAX);
   localparam int RST_AW = $clog2(MAX_RESTARTS);

   localparam logic [1:0] OP_KEY = 2'd0;
   localparam logic [1:0] OP_VALUE = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_KEY_LEN = 2'd1;
   localparam logic [1:0] ERR_TABLE_FULL = 2'd2;
   localparam logic [1:0] ERR_FINISHED = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] data_byte;
      logic [8:0] key_length;
      logic [31:0] value_length;
   } req_type;

   typedef struct packed {
      logic [39:0] data_word;
      logic [2:0] byte_count;
      logic last_of_run;
      logic [31:0] size_estimate;
      logic [1:0] error;
   } rsp_type;

   typedef struct packed {
      logic [39:0] word;
      logic [2:0] cnt;
   } varint_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic read_tab;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic empty;
      logic fin;
      logic last;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_EMIT,
      ST_FIN_READ,
      ST_FIN_OUT
   } state_type;

   // little-endian base-128 encoding, upper bytes stay zero
   function automatic varint_type varint_enc(input logic [31:0] v);
      varint_type r;
      logic c1, c2, c3, c4;
      c1 = |v[31:7];
      c2 = |v[31:14];
      c3 = |v[31:21];
      c4 = |v[31:28];
      r.word = {4'b0, v[31:28], c4, v[27:21], c3, v[20:14], c2, v[13:7], c1, v[6:0]};
      r.cnt = c4 ? 3'd5 : c3 ? 3'd4 : c2 ? 3'd3 : c1 ? 3'd2 : 3'd1;
      return r;
   endfunction

endpackage

@@ rtl/sbpe_ctrl.sv @@
module sbpe_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input sbpe_pkg::status_type status,
   output sbpe_pkg::cmd_type cmd
);
   import sbpe_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.accept = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.empty) begin
               state_in = ST_IDLE;
            end else if (status.fin) begin
               state_in = ST_FIN_READ;
            end else if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.last) state_in = ST_IDLE;
            end
         end
         ST_FIN_READ: begin
            cmd.read_tab = 1'b1;
            state_in = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in = status.last ? ST_IDLE : ST_FIN_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/sbpe_datapath.sv @@
module sbpe_datapath (
   input logic clock,
   input logic reset,
   input sbpe_pkg::req_type req_payload,
   input logic csr_valid,
   input logic [15:0] csr_data,
   input sbpe_pkg::cmd_type cmd,
   output sbpe_pkg::status_type status,
   output logic rsp_valid,
   input logic rsp_ready,
   output sbpe_pkg::rsp_type rsp_payload
);
   import sbpe_pkg::*;

   localparam int RCW = $clog2(MAX_RESTARTS + 1);
   localparam int NW = $clog2(MAX_RESTARTS + 2);

   logic [7:0] prev_key_mem [KEY_MAX];
   logic [31:0] table_mem [MAX_RESTARTS];

   req_type req_ff;
   logic [7:0] key_rd_ff;
   logic [31:0] tab_rd_ff;
   logic [15:0] interval_ff;
   logic [8:0] prev_len_ff, prev_len_in;
   logic [8:0] key_pos_ff, key_pos_in;
   logic still_ff, still_in;
   logic [8:0] shared_ff, shared_in;
   logic [15:0] entry_ff, entry_in;
   logic [31:0] offset_ff, offset_in;
   logic [RCW-1:0] rc_ff, rc_in;
   logic finished_ff, finished_in;

   logic [39:0] slot_word_ff [4];
   logic [2:0] slot_cnt_ff [4];
   logic [39:0] slot_word_in [4];
   logic [2:0] slot_cnt_in [4];
   logic [NW-1:0] n_ff, n_in, idx_ff;
   logic fin_ff, fin_in;
   logic [1:0] err_ff, err_in;
   logic [31:0] size_ff, size_in;
   logic tab_wr;

   logic rsp_valid_ff;
   rsp_type rsp_ff;

   // key byte evaluation terms
   logic restart_now, full, still_eff, match, key_end, hdr, need_byte;
   logic [9:0] p_next;
   logic [8:0] hlen, sh_val, unsh_val;
   varint_type v0, v1, v2;
   logic [5:0] total;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= 16'd16;
      end else if (csr_valid) begin
         interval_ff <= csr_data;
      end
   end

   // request latch and memory reads
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_payload;
         key_rd_ff <= prev_key_mem[key_pos_ff[KEY_AW-1:0]];
      end
      if (cmd.read_tab) tab_rd_ff <= table_mem[idx_ff[RST_AW-1:0]];
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (cmd.eval && req_ff.operation == OP_KEY && !finished_ff &&
          req_ff.key_length != 9'd0 && req_ff.key_length <= 9'(KEY_MAX)) begin
         prev_key_mem[key_pos_ff[KEY_AW-1:0]] <= req_ff.data_byte;
      end
      if (cmd.eval && tab_wr) table_mem[rc_ff[RST_AW-1:0]] <= offset_ff;
   end

   // evaluation of one request
   always_comb begin
      p_next = {1'b0, key_pos_ff} + 10'd1;
      restart_now = (key_pos_ff == 9'd0) && (entry_ff >= interval_ff);
      full = rc_ff >= RCW'(MAX_RESTARTS);
      still_eff = restart_now ? 1'b0 : still_ff;
      match = still_eff && (key_pos_ff < prev_len_ff) && (key_rd_ff == req_ff.data_byte);
      key_end = p_next >= {1'b0, req_ff.key_length};
      hlen = key_end ? p_next[8:0] : req_ff.key_length;
      hdr = match ? key_end : still_eff;
      need_byte = !match;
      sh_val = match ? shared_ff + 9'd1 : shared_ff;
      unsh_val = match ? 9'd0 : hlen - shared_ff;
      v0 = varint_enc({23'b0, sh_val});
      v1 = varint_enc({23'b0, unsh_val});
      v2 = varint_enc(req_ff.value_length);
      total = (hdr ? 6'(v0.cnt) + 6'(v1.cnt) + 6'(v2.cnt) : 6'd0) + {5'b0, need_byte};

      prev_len_in = prev_len_ff;
      key_pos_in = key_pos_ff;
      still_in = still_ff;
      shared_in = shared_ff;
      entry_in = entry_ff;
      offset_in = offset_ff;
      rc_in = rc_ff;
      finished_in = finished_ff;
      tab_wr = 1'b0;
      for (int i = 0; i < 4; i++) begin
         slot_word_in[i] = '0;
         slot_cnt_in[i] = '0;
      end
      n_in = NW'(1);
      fin_in = 1'b0;
      err_in = ERR_NONE;

      if (req_ff.operation == OP_CLEAR) begin
         prev_len_in = '0;
         key_pos_in = '0;
         still_in = 1'b1;
         shared_in = '0;
         entry_in = '0;
         offset_in = '0;
         rc_in = RCW'(1);
         finished_in = 1'b0;
      end else if (finished_ff) begin
         err_in = ERR_FINISHED;
      end else if (req_ff.operation == OP_KEY) begin
         if (req_ff.key_length == 9'd0 || req_ff.key_length > 9'(KEY_MAX)) begin
            err_in = ERR_KEY_LEN;
         end else begin
            if (restart_now) begin
               entry_in = '0;
               if (!full) begin
                  tab_wr = 1'b1;
                  rc_in = rc_ff + RCW'(1);
               end else begin
                  err_in = ERR_TABLE_FULL;
               end
            end
            // compact header and suffix byte into slots
            if (hdr) begin
               slot_word_in[0] = v0.word;
               slot_cnt_in[0] = v0.cnt;
               slot_word_in[1] = v1.word;
               slot_cnt_in[1] = v1.cnt;
               slot_word_in[2] = v2.word;
               slot_cnt_in[2] = v2.cnt;
               slot_word_in[3] = {32'b0, req_ff.data_byte};
               slot_cnt_in[3] = 3'd1;
               n_in = need_byte ? NW'(4) : NW'(3);
            end else begin
               slot_word_in[0] = {32'b0, req_ff.data_byte};
               slot_cnt_in[0] = 3'd1;
               n_in = need_byte ? NW'(1) : NW'(0);
            end
            offset_in = offset_ff + {26'b0, total};
            shared_in = match ? shared_ff + 9'd1 : shared_ff;
            still_in = match ? still_eff : 1'b0;
            key_pos_in = p_next[8:0];
            if (key_end) begin
               prev_len_in = p_next[8:0];
               key_pos_in = '0;
               still_in = 1'b1;
               shared_in = '0;
               entry_in = (restart_now ? 16'd0 : entry_ff) + 16'd1;
            end
         end
      end else if (req_ff.operation == OP_VALUE) begin
         slot_word_in[0] = {32'b0, req_ff.data_byte};
         slot_cnt_in[0] = 3'd1;
         offset_in = offset_ff + 32'd1;
      end else begin
         key_pos_in = '0;
         still_in = 1'b1;
         shared_in = '0;
         finished_in = 1'b1;
         fin_in = 1'b1;
         n_in = NW'(rc_ff) + NW'(1);
         offset_in = offset_ff + {{(30 - RCW){1'b0}}, rc_ff, 2'b0} + 32'd4;
      end

      if (finished_in) size_in = offset_in;
      else size_in = offset_in + {{(30 - RCW){1'b0}}, rc_in, 2'b0} + 32'd4;
   end

   // block state and emission plan
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_len_ff <= '0;
         key_pos_ff <= '0;
         still_ff <= 1'b1;
         shared_ff <= '0;
         entry_ff <= '0;
         offset_ff <= '0;
         rc_ff <= RCW'(1);
         finished_ff <= 1'b0;
         n_ff <= '0;
         idx_ff <= '0;
         fin_ff <= 1'b0;
      end else if (cmd.eval) begin
         prev_len_ff <= prev_len_in;
         key_pos_ff <= key_pos_in;
         still_ff <= still_in;
         shared_ff <= shared_in;
         entry_ff <= entry_in;
         offset_ff <= offset_in;
         rc_ff <= rc_in;
         finished_ff <= finished_in;
         n_ff <= n_in;
         idx_ff <= '0;
         fin_ff <= fin_in;
      end else if (cmd.load_out) begin
         idx_ff <= idx_ff + NW'(1);
      end
   end

   // plan payload
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         slot_word_ff <= slot_word_in;
         slot_cnt_ff <= slot_cnt_in;
         err_ff <= err_in;
         size_ff <= size_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (fin_ff) begin
            if (idx_ff < NW'(rc_ff)) begin
               rsp_ff.data_word <= (idx_ff == '0) ? 40'd0 : {8'b0, tab_rd_ff};
            end else begin
               rsp_ff.data_word <= {{(40 - RCW){1'b0}}, rc_ff};
            end
            rsp_ff.byte_count <= 3'd4;
         end else begin
            rsp_ff.data_word <= slot_word_ff[idx_ff[1:0]];
            rsp_ff.byte_count <= slot_cnt_ff[idx_ff[1:0]];
         end
         rsp_ff.last_of_run <= status.last;
         rsp_ff.size_estimate <= size_ff;
         rsp_ff.error <= err_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.empty = n_ff == '0;
   assign status.fin = fin_ff;
   assign status.last = (idx_ff + NW'(1)) == n_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/sorted_block_prefix_encoder.sv @@
// each request is latched, evaluated, then its results go out one by one
// a key byte request gives up to four results and a value byte one; finish
// reads the restart table for each word; no new request is taken until done
// reset: synchronous, clears block state, restart interval returns to 16
// the previous key memory is not cleared; only written bytes are compared
module sorted_block_prefix_encoder (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input sbpe_pkg::req_type req_payload,
   output logic rsp_valid,
   input logic rsp_ready,
   output sbpe_pkg::rsp_type rsp_payload,
   input logic csr_valid,
   output logic csr_ready,
   input logic [15:0] csr_data
);
   import sbpe_pkg::*;

   cmd_type cmd;
   status_type status;

   assign csr_ready = !reset;

   // sequencer
   sbpe_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   // encoder state and output register
   sbpe_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .req_payload(req_payload),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .cmd(cmd),
      .status(status),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
